FILE: hdl/suffix_automaton_predictor_with_queries_top_macros.svh
// Assertion macros used by the predictor top module.
`ifndef SUFFIX_AUTOMATON_PREDICTOR_WITH_QUERIES_TOP_MACROS_SVH
`define SUFFIX_AUTOMATON_PREDICTOR_WITH_QUERIES_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet in reset.
`define SAP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SAP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sap_pkg.sv
// Types and constants of the suffix automaton predictor.
package sap_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int SYM_W         = 8;
	localparam int MAX_LENGTH    = 1024;
	localparam int NODE_MAX      = 2 * MAX_LENGTH + 5;
	localparam int NODE_W        = 12;
	localparam int LEN_W         = 11;
	localparam int HIST_AW       = 10;
	localparam int TR_AW         = NODE_W + SYM_W;
	localparam int TR_DEPTH      = NODE_MAX * ALPHABET_SIZE;
	localparam int PRED_W        = 9;

	localparam logic [PRED_W-1:0] PRED_NONE   = 9'h1FF;
	localparam logic [PRED_W-1:0] PRED_MASKED = 9'h1FE;

	typedef struct packed {
		logic [NODE_W-1:0] link;
		logic [LEN_W-1:0]  len;
		logic [LEN_W-1:0]  endp;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_P_RD,
		ST_P_CHK,
		ST_P_END,
		ST_P_HIST,
		ST_DECIDE,
		ST_A_RD,
		ST_A_LEN,
		ST_NCLR,
		ST_W1_RD,
		ST_W1_CHK,
		ST_F_CHK,
		ST_CPY,
		ST_W2_RD,
		ST_W2_CHK,
		ST_QLNK,
		ST_CUR,
		ST_E_RD,
		ST_E_CHK,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/sap_if.sv
// Valid/ready channel interfaces for query/symbol beats and result beats.
interface sap_in_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [sap_pkg::SYM_W-1:0]  symbol;
	logic                       position_enabled;
	logic                       start_sequence;

	modport source (output valid, func, symbol, position_enabled, start_sequence,
		input ready);
	modport sink (input valid, func, symbol, position_enabled, start_sequence,
		output ready);
endinterface

interface sap_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [sap_pkg::PRED_W-1:0] prediction;
	logic                              history_full;

	modport source (output valid, prediction, history_full, input ready);
	modport sink (input valid, prediction, history_full, output ready);
endinterface

FILE: hdl/suffix_automaton_predictor_with_queries_top.sv
// Online suffix automaton predictor: sequencer plus transition, node and history RAMs.
// A masked query goes straight to the result; a query walks suffix links from the current node;
//   a start flag adds a root row clear. Appends add a row clear for the new node, a row
//   copy per clone, and a node-by-node pass on each suffix-link walk.
// Throughput: one beat at a time; the next beat is taken the cycle after the result loads.
// Reset: asynchronous, empty automaton; a pass then zeroes the root row and entry.
`include "suffix_automaton_predictor_with_queries_top_macros.svh"

module suffix_automaton_predictor_with_queries_top (
	input  logic        clk,
	input  logic        arst_n,
	sap_in_if.sink      req,
	sap_out_if.source   rsp
);

	sap_pkg::state_t state_q, state_d;

	// item
	logic                          func_q, en_q;
	logic [sap_pkg::SYM_W-1:0]     sym_q;
	// automaton control state
	logic [sap_pkg::NODE_W-1:0]    node_count_q, cur_q;
	logic [sap_pkg::LEN_W-1:0]     hist_len_q;
	logic [sap_pkg::SYM_W-1:0]     prev_q;
	logic                          prev_vld_q;
	// walk registers
	logic [sap_pkg::NODE_W-1:0]    p_q, q_q, cl_q, cn_q, cur_link_q;
	logic [sap_pkg::LEN_W-1:0]     cur_len_q, plen_q;
	sap_pkg::node_t                qnode_q;
	logic [8:0]                    cnt_q;
	logic [sap_pkg::PRED_W-1:0]    pred_q;
	logic                          full_q;
	// result register
	logic                          out_vld_q;
	logic [sap_pkg::PRED_W-1:0]    out_pred_q;
	logic                          out_full_q;

	// RAM ports
	logic                          tr_we;
	logic [sap_pkg::TR_AW-1:0]     tr_waddr, tr_raddr;
	logic [sap_pkg::NODE_W-1:0]    tr_wdata, tr_rdata;
	logic                          nd_we;
	logic [sap_pkg::NODE_W-1:0]    nd_waddr, nd_raddr;
	sap_pkg::node_t                nd_wdata, nd_rdata;
	logic                          hs_we;
	logic [sap_pkg::HIST_AW-1:0]   hs_waddr, hs_raddr;
	logic [sap_pkg::SYM_W-1:0]     hs_wdata, hs_rdata;

	sap_ram #(.DEPTH(sap_pkg::TR_DEPTH), .WIDTH(sap_pkg::NODE_W)) u_trans (
		.clk, .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.raddr(tr_raddr), .rdata(tr_rdata));

	sap_ram #(.DEPTH(sap_pkg::NODE_MAX), .WIDTH(sap_pkg::NODE_BITS)) u_node (
		.clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(nd_raddr), .rdata(nd_rdata));

	sap_ram #(.DEPTH(sap_pkg::MAX_LENGTH), .WIDTH(sap_pkg::SYM_W)) u_hist (
		.clk, .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
		.raddr(hs_raddr), .rdata(hs_rdata));

	// handshakes
	logic in_fire, out_load, out_fire;
	assign req.ready = (state_q == sap_pkg::ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_fire  = rsp.valid && rsp.ready;
	assign out_load  = (state_q == sap_pkg::ST_DONE) && (!out_vld_q || rsp.ready);

	assign rsp.valid        = out_vld_q;
	assign rsp.prediction   = $signed(out_pred_q);
	assign rsp.history_full = out_full_q;

	// derived conditions
	logic                         t_hit, p_root, masked, rep_sym, hist_full_c, sweep_end;
	logic [sap_pkg::NODE_W:0]     nxt_pos;
	logic [sap_pkg::LEN_W-1:0]    plen_inc;
	assign t_hit       = (tr_rdata != '0);
	assign p_root      = (p_q == '0);
	assign masked      = !func_q && !en_q;
	assign rep_sym     = prev_vld_q && (prev_q == sym_q);
	assign hist_full_c = (hist_len_q >= sap_pkg::LEN_W'(sap_pkg::MAX_LENGTH));
	assign sweep_end   = (cnt_q[7:0] == 8'hFF);
	assign nxt_pos     = (sap_pkg::NODE_W+1)'(nd_rdata.endp) + 1'b1;
	assign plen_inc    = plen_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sap_pkg::ST_INIT: begin
				if (sweep_end) state_d = sap_pkg::ST_IDLE;
			end
			sap_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (req.start_sequence) state_d = sap_pkg::ST_CLR;
					else if (!req.func && !req.position_enabled) state_d = sap_pkg::ST_DONE;
					else state_d = sap_pkg::ST_P_RD;
				end
			end
			sap_pkg::ST_CLR: begin
				if (sweep_end) state_d = masked ? sap_pkg::ST_DONE : sap_pkg::ST_P_RD;
			end
			sap_pkg::ST_P_RD:   state_d = sap_pkg::ST_P_CHK;
			sap_pkg::ST_P_CHK: begin
				if (t_hit) state_d = sap_pkg::ST_P_END;
				else if (p_root) state_d = sap_pkg::ST_DECIDE;
				else state_d = sap_pkg::ST_P_RD;
			end
			sap_pkg::ST_P_END: begin
				if (nxt_pos < (sap_pkg::NODE_W+1)'(hist_len_q)) state_d = sap_pkg::ST_P_HIST;
				else state_d = sap_pkg::ST_DECIDE;
			end
			sap_pkg::ST_P_HIST: state_d = sap_pkg::ST_DECIDE;
			sap_pkg::ST_DECIDE: begin
				if (func_q && !rep_sym && !hist_full_c) state_d = sap_pkg::ST_A_RD;
				else state_d = sap_pkg::ST_DONE;
			end
			sap_pkg::ST_A_RD:   state_d = sap_pkg::ST_A_LEN;
			sap_pkg::ST_A_LEN:  state_d = sap_pkg::ST_NCLR;
			sap_pkg::ST_NCLR: begin
				if (sweep_end) state_d = sap_pkg::ST_W1_RD;
			end
			sap_pkg::ST_W1_RD:  state_d = sap_pkg::ST_W1_CHK;
			sap_pkg::ST_W1_CHK: begin
				if (t_hit) state_d = sap_pkg::ST_F_CHK;
				else if (p_root) state_d = sap_pkg::ST_CUR;
				else state_d = sap_pkg::ST_W1_RD;
			end
			sap_pkg::ST_F_CHK: begin
				if (plen_inc == nd_rdata.len) state_d = sap_pkg::ST_CUR;
				else state_d = sap_pkg::ST_CPY;
			end
			sap_pkg::ST_CPY: begin
				if (cnt_q[8]) state_d = sap_pkg::ST_W2_RD;
			end
			sap_pkg::ST_W2_RD:  state_d = sap_pkg::ST_W2_CHK;
			sap_pkg::ST_W2_CHK: begin
				if (tr_rdata != q_q || p_root) state_d = sap_pkg::ST_QLNK;
				else state_d = sap_pkg::ST_W2_RD;
			end
			sap_pkg::ST_QLNK:   state_d = sap_pkg::ST_CUR;
			sap_pkg::ST_CUR:    state_d = sap_pkg::ST_E_RD;
			sap_pkg::ST_E_RD:   state_d = sap_pkg::ST_E_CHK;
			sap_pkg::ST_E_CHK: begin
				if (nd_rdata.endp == hist_len_q || p_root) state_d = sap_pkg::ST_FIN;
				else state_d = sap_pkg::ST_E_RD;
			end
			sap_pkg::ST_FIN:    state_d = sap_pkg::ST_DONE;
			sap_pkg::ST_DONE: begin
				if (out_load) state_d = sap_pkg::ST_IDLE;
			end
			default:            state_d = sap_pkg::ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		tr_we    = 1'b0;
		tr_waddr = {p_q, sym_q};
		tr_wdata = '0;
		tr_raddr = {p_q, sym_q};
		nd_we    = 1'b0;
		nd_waddr = p_q;
		nd_wdata = '0;
		nd_raddr = p_q;
		hs_we    = 1'b0;
		hs_waddr = hist_len_q[sap_pkg::HIST_AW-1:0];
		hs_wdata = sym_q;
		hs_raddr = nxt_pos[sap_pkg::HIST_AW-1:0];
		unique case (state_q)
			sap_pkg::ST_INIT: begin
				// after reset: sweep the root row and zero the root entry
				tr_we    = 1'b1;
				tr_waddr = {sap_pkg::NODE_W'(0), cnt_q[7:0]};
				nd_we    = 1'b1;
				nd_waddr = '0;
			end
			sap_pkg::ST_IDLE: begin
				// root node entry zeroed on a start beat
				nd_we    = in_fire && req.start_sequence;
				nd_waddr = '0;
			end
			sap_pkg::ST_CLR: begin
				tr_we    = 1'b1;
				tr_waddr = {sap_pkg::NODE_W'(0), cnt_q[7:0]};
			end
			sap_pkg::ST_P_CHK, sap_pkg::ST_W1_CHK: begin
				nd_raddr = tr_rdata;
				if (state_q == sap_pkg::ST_W1_CHK && !t_hit) begin
					tr_we    = 1'b1;
					tr_wdata = cn_q;
				end
			end
			sap_pkg::ST_A_RD: begin
				nd_raddr = cur_q;
				hs_we    = 1'b1;
			end
			sap_pkg::ST_NCLR: begin
				tr_we    = 1'b1;
				tr_waddr = {cn_q, cnt_q[7:0]};
			end
			sap_pkg::ST_F_CHK: begin
				nd_we    = (plen_inc != nd_rdata.len);
				nd_waddr = node_count_q;
				nd_wdata = '{link: nd_rdata.link, len: plen_inc, endp: nd_rdata.endp};
			end
			sap_pkg::ST_CPY: begin
				tr_raddr = {q_q, cnt_q[7:0]};
				tr_we    = (cnt_q != '0);
				tr_waddr = {cl_q, 8'(cnt_q - 1'b1)};
				tr_wdata = tr_rdata;
			end
			sap_pkg::ST_W2_CHK: begin
				tr_we    = (tr_rdata == q_q);
				tr_wdata = cl_q;
			end
			sap_pkg::ST_QLNK: begin
				nd_we    = 1'b1;
				nd_waddr = q_q;
				nd_wdata = '{link: cl_q, len: qnode_q.len, endp: qnode_q.endp};
			end
			sap_pkg::ST_CUR: begin
				nd_we    = 1'b1;
				nd_waddr = cn_q;
				nd_wdata = '{link: cur_link_q, len: cur_len_q, endp: hist_len_q};
			end
			sap_pkg::ST_E_CHK: begin
				nd_we    = (nd_rdata.endp != hist_len_q);
				nd_wdata = '{link: nd_rdata.link, len: nd_rdata.len, endp: hist_len_q};
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sap_pkg::ST_INIT;
			node_count_q <= sap_pkg::NODE_W'(1);
			cur_q        <= '0;
			hist_len_q   <= '0;
			prev_vld_q   <= 1'b0;
			out_vld_q    <= 1'b0;
			cnt_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) out_vld_q <= 1'b1;
			else if (out_fire) out_vld_q <= 1'b0;
			if (in_fire && req.start_sequence) begin
				node_count_q <= sap_pkg::NODE_W'(1);
				cur_q        <= '0;
				hist_len_q   <= '0;
				prev_vld_q   <= 1'b0;
			end
			case (state_q)
				sap_pkg::ST_INIT, sap_pkg::ST_CLR, sap_pkg::ST_NCLR, sap_pkg::ST_CPY:
					cnt_q <= cnt_q + 1'b1;
				sap_pkg::ST_A_RD: begin
					node_count_q <= node_count_q + 1'b1;
					cnt_q        <= '0;
				end
				sap_pkg::ST_F_CHK: begin
					cnt_q <= '0;
					if (plen_inc != nd_rdata.len) node_count_q <= node_count_q + 1'b1;
				end
				sap_pkg::ST_FIN: begin
					cur_q      <= cn_q;
					hist_len_q <= hist_len_q + 1'b1;
					prev_vld_q <= 1'b1;
				end
				default: begin
					if (in_fire) cnt_q <= '0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pred_q <= pred_q;
			out_full_q <= full_q;
		end
		case (state_q)
			sap_pkg::ST_IDLE: begin
				if (in_fire) begin
					func_q <= req.func;
					sym_q  <= req.symbol;
					en_q   <= req.position_enabled;
					p_q    <= req.start_sequence ? '0 : cur_q;
					pred_q <= sap_pkg::PRED_MASKED;
					full_q <= 1'b0;
				end
			end
			sap_pkg::ST_P_CHK: begin
				if (t_hit) q_q <= tr_rdata;
				else if (p_root) pred_q <= sap_pkg::PRED_NONE;
				else p_q <= nd_rdata.link;
			end
			sap_pkg::ST_P_END: begin
				pred_q <= sap_pkg::PRED_NONE;
			end
			sap_pkg::ST_P_HIST: pred_q <= {1'b0, hs_rdata};
			sap_pkg::ST_DECIDE: begin
				if (func_q && !rep_sym && hist_full_c) full_q <= 1'b1;
			end
			sap_pkg::ST_A_RD: begin
				cn_q <= node_count_q;
				p_q  <= cur_q;
			end
			sap_pkg::ST_A_LEN: begin
				cur_len_q  <= nd_rdata.len + 1'b1;
				cur_link_q <= '0;
			end
			sap_pkg::ST_W1_CHK: begin
				if (t_hit) begin
					q_q    <= tr_rdata;
					plen_q <= nd_rdata.len;
				end else if (!p_root) begin
					p_q <= nd_rdata.link;
				end
			end
			sap_pkg::ST_F_CHK: begin
				qnode_q    <= nd_rdata;
				cur_link_q <= q_q;
				cl_q       <= node_count_q;
			end
			sap_pkg::ST_W2_CHK: begin
				if (tr_rdata == q_q && !p_root) p_q <= nd_rdata.link;
			end
			sap_pkg::ST_QLNK:   cur_link_q <= cl_q;
			sap_pkg::ST_CUR: begin
				p_q    <= cur_link_q;
				prev_q <= sym_q;
			end
			sap_pkg::ST_E_CHK: begin
				if (!p_root) p_q <= nd_rdata.link;
			end
			default: begin
			end
		endcase
	end

	`SAP_ASSERT_IMP(a_node_bound, 1'b1, node_count_q <= sap_pkg::NODE_W'(sap_pkg::NODE_MAX), "node count past capacity")
	`SAP_ASSERT_IMP(a_hist_bound, 1'b1, hist_len_q <= sap_pkg::LEN_W'(sap_pkg::MAX_LENGTH), "history length past capacity")
	`SAP_ASSERT_NXT(a_busy, in_fire, state_q != sap_pkg::ST_IDLE, "accepted beat left sequencer idle")
	`SAP_ASSERT_NXT(a_append, state_q == sap_pkg::ST_FIN, hist_len_q == $past(hist_len_q) + 1'b1, "append did not grow history")

endmodule

FILE: hdl/sap_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module sap_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
